>>> sv/ccb_pkg.sv
// Shared types, codes, constants and helpers of the clipped color-key blit unit.
package ccb_pkg;

  localparam logic [12:0] MAX_DIMENSION = 13'd4096;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_PIXEL = 1'b1;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_EMPTY   = 2'd1;
  localparam logic [1:0] STATUS_NO_BLIT = 2'd2;

  typedef enum logic [2:0] {
    REG_SRC_WIDTH  = 3'd0,
    REG_SRC_HEIGHT = 3'd1,
    REG_SCR_WIDTH  = 3'd2,
    REG_SCR_HEIGHT = 3'd3,
    REG_PITCH      = 3'd4,
    REG_COLOR_KEY  = 3'd5
  } cfg_index_t;

  typedef struct packed {
    logic [12:0] source_image_width;
    logic [12:0] source_image_height;
    logic [12:0] screen_width;
    logic [12:0] screen_height;
    logic [12:0] scanline_pitch;
    logic [31:0] color_key;
  } cfg_regs_t;

  typedef enum logic [1:0] {
    JOB_START_OK    = 2'd0,
    JOB_START_EMPTY = 2'd1,
    JOB_PIXEL       = 2'd2,
    JOB_NO_BLIT     = 2'd3
  } job_kind_t;

  typedef struct packed {
    job_kind_t   kind;
    logic [12:0] clip_w;
    logic [12:0] clip_h;
    logic [12:0] src_row;
    logic [12:0] src_col;
    logic [12:0] dst_row;
    logic [12:0] dst_col;
    logic [31:0] pix;
    logic        last;
  } job_t;

  // Dimension registers above the maximum act as the maximum.
  function automatic logic [12:0] dim_limit(input logic [12:0] v);
    return (v > MAX_DIMENSION) ? MAX_DIMENSION : v;
  endfunction

endpackage

>>> sv/ccb_if.sv
// Channel interfaces of the blit unit: pixel/command input, result output, config write.
interface ccb_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [11:0] source_x;
  logic [11:0] source_y;
  logic [12:0] rect_width;
  logic [12:0] rect_height;
  logic [11:0] dest_x;
  logic [11:0] dest_y;
  logic [31:0] pixel_in;

  modport source (output valid, command, source_x, source_y, rect_width, rect_height,
                  dest_x, dest_y, pixel_in, input ready);
  modport sink   (input valid, command, source_x, source_y, rect_width, rect_height,
                  dest_x, dest_y, pixel_in, output ready);
endinterface

interface ccb_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [12:0] clip_width;
  logic [12:0] clip_height;
  logic [23:0] source_addr;
  logic [23:0] dest_addr;
  logic [31:0] pixel_out;
  logic        write_enable;
  logic        last;

  modport source (output valid, status, clip_width, clip_height, source_addr, dest_addr,
                  pixel_out, write_enable, last, input ready);
  modport sink   (input valid, status, clip_width, clip_height, source_addr, dest_addr,
                  pixel_out, write_enable, last, output ready);
endinterface

interface ccb_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> sv/ccb_front.sv
// Front end: accept beats, clip start rectangles, run the raster counters, emit jobs.
module ccb_front (
  input  logic               clk,
  input  logic               rst_n,
  ccb_in_if.sink             in_ch,
  input  ccb_pkg::cfg_regs_t cfg,
  input  logic               q_full,
  output logic               push_valid,
  output ccb_pkg::job_t      push_job
);

  // Length of [start, start+len) clipped to [0, bound); zero when empty.
  function automatic logic [12:0] clip_span(input logic [12:0] start,
                                            input logic [12:0] len,
                                            input logic [12:0] bound);
    logic [13:0] span_end;
    span_end = {1'b0, start} + {1'b0, len};
    if (span_end > {1'b0, bound}) span_end = {1'b0, bound};
    return (span_end > {1'b0, start}) ? 13'(span_end - {1'b0, start}) : 13'd0;
  endfunction

  logic        active_r, active_nxt;
  logic [11:0] org_sc_r, org_sc_nxt, org_sr_r, org_sr_nxt;
  logic [11:0] org_dc_r, org_dc_nxt, org_dr_r, org_dr_nxt;
  logic [12:0] span_w_r, span_w_nxt, span_h_r, span_h_nxt;
  logic [12:0] col_r, col_nxt, row_r, row_nxt;

  logic        accept;
  logic [12:0] lim_sw, lim_sh, lim_iw, lim_ih;
  logic [12:0] fit_w, fit_h, cw, ch;
  logic        on_screen, start_ok, end_row, end_all;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;
  assign push_valid  = accept;

  always_comb begin
    lim_sw = ccb_pkg::dim_limit(cfg.screen_width);
    lim_sh = ccb_pkg::dim_limit(cfg.screen_height);
    lim_iw = ccb_pkg::dim_limit(cfg.source_image_width);
    lim_ih = ccb_pkg::dim_limit(cfg.source_image_height);
    fit_w  = clip_span({1'b0, in_ch.source_x}, in_ch.rect_width, lim_iw);
    fit_h  = clip_span({1'b0, in_ch.source_y}, in_ch.rect_height, lim_ih);
    on_screen = (fit_w != 13'd0) && (fit_h != 13'd0) &&
                ({1'b0, in_ch.dest_x} < lim_sw) && ({1'b0, in_ch.dest_y} < lim_sh);
    cw = on_screen ? clip_span({1'b0, in_ch.dest_x}, fit_w, lim_sw) : 13'd0;
    ch = on_screen ? clip_span({1'b0, in_ch.dest_y}, fit_h, lim_sh) : 13'd0;
    start_ok = (cw != 13'd0) && (ch != 13'd0);
    end_row  = ({1'b0, col_r} + 14'd1) >= {1'b0, span_w_r};
    end_all  = end_row && (({1'b0, row_r} + 14'd1) >= {1'b0, span_h_r});
  end

  // Build the job for the back end.
  always_comb begin
    push_job = '0;
    if (in_ch.command == ccb_pkg::CMD_START) begin
      if (start_ok) begin
        push_job.kind   = ccb_pkg::JOB_START_OK;
        push_job.clip_w = cw;
        push_job.clip_h = ch;
      end else begin
        push_job.kind = ccb_pkg::JOB_START_EMPTY;
      end
    end else if (active_r) begin
      push_job.kind    = ccb_pkg::JOB_PIXEL;
      push_job.src_row = {1'b0, org_sr_r} + row_r;
      push_job.src_col = {1'b0, org_sc_r} + col_r;
      push_job.dst_row = {1'b0, org_dr_r} + row_r;
      push_job.dst_col = {1'b0, org_dc_r} + col_r;
      push_job.pix     = in_ch.pixel_in;
      push_job.last    = end_all;
    end else begin
      push_job.kind = ccb_pkg::JOB_NO_BLIT;
    end
  end

  // Advance the blit state on each accepted beat.
  always_comb begin
    active_nxt = active_r;
    org_sc_nxt = org_sc_r;
    org_sr_nxt = org_sr_r;
    org_dc_nxt = org_dc_r;
    org_dr_nxt = org_dr_r;
    span_w_nxt = span_w_r;
    span_h_nxt = span_h_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    if (accept) begin
      if (in_ch.command == ccb_pkg::CMD_START) begin
        active_nxt = start_ok;
        if (start_ok) begin
          org_sc_nxt = in_ch.source_x;
          org_sr_nxt = in_ch.source_y;
          org_dc_nxt = in_ch.dest_x;
          org_dr_nxt = in_ch.dest_y;
          span_w_nxt = cw;
          span_h_nxt = ch;
          col_nxt    = 13'd0;
          row_nxt    = 13'd0;
        end
      end else if (active_r) begin
        if (end_all) begin
          active_nxt = 1'b0;
          col_nxt    = 13'd0;
          row_nxt    = 13'd0;
        end else if (end_row) begin
          col_nxt = 13'd0;
          row_nxt = row_r + 13'd1;
        end else begin
          col_nxt = col_r + 13'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      org_sc_r <= '0;
      org_sr_r <= '0;
      org_dc_r <= '0;
      org_dr_r <= '0;
      span_w_r <= '0;
      span_h_r <= '0;
      col_r    <= '0;
      row_r    <= '0;
    end else begin
      active_r <= active_nxt;
      org_sc_r <= org_sc_nxt;
      org_sr_r <= org_sr_nxt;
      org_dc_r <= org_dc_nxt;
      org_dr_r <= org_dr_nxt;
      span_w_r <= span_w_nxt;
      span_h_r <= span_h_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
    end
  end

endmodule

>>> sv/ccb_queue.sv
// Short job queue between the front and back ends.
module ccb_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  input  ccb_pkg::job_t push_job,
  output logic          full,
  output logic          pop_valid,
  input  logic          pop_ready,
  output ccb_pkg::job_t pop_job
);

  ccb_pkg::job_t                slot_r [ccb_pkg::QUEUE_DEPTH];
  logic [ccb_pkg::QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [ccb_pkg::QCNT_W-1:0]   count_r, count_nxt;
  logic                         do_push, do_pop;

  localparam logic [ccb_pkg::QPTR_W-1:0] PTR_LAST = ccb_pkg::QPTR_W'(ccb_pkg::QUEUE_DEPTH - 1);
  localparam logic [ccb_pkg::QCNT_W-1:0] CNT_FULL = ccb_pkg::QCNT_W'(ccb_pkg::QUEUE_DEPTH);

  assign full      = (count_r == CNT_FULL);
  assign pop_valid = (count_r != '0);
  assign pop_job   = slot_r[rd_ptr_r];
  assign do_push   = push_valid && !full;
  assign do_pop    = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    if (do_pop)  rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    if (do_push && !do_pop)      count_nxt = count_r + 1'b1;
    else if (do_pop && !do_push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= push_job;
  end

endmodule

>>> sv/ccb_back.sv
// Back end: form addresses, apply the color key and hold the result beat.
module ccb_back (
  input  logic               clk,
  input  logic               rst_n,
  input  ccb_pkg::cfg_regs_t cfg,
  input  logic               pop_valid,
  output logic               pop_ready,
  input  ccb_pkg::job_t      pop_job,
  ccb_out_if.source          out_ch
);

  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  status_r, status_nxt;
  logic [12:0] clip_w_r, clip_w_nxt, clip_h_r, clip_h_nxt;
  logic [23:0] src_addr_r, src_addr_nxt, dst_addr_r, dst_addr_nxt;
  logic [31:0] pix_r, pix_nxt;
  logic        we_r, we_nxt, last_r, last_nxt;

  logic        load, keyed;
  logic [12:0] lim_iw;
  logic [25:0] src_prod, dst_prod;

  assign pop_ready = !out_valid_r || out_ch.ready;
  assign load      = pop_valid && pop_ready;

  always_comb begin
    lim_iw   = ccb_pkg::dim_limit(cfg.source_image_width);
    src_prod = pop_job.src_row * lim_iw;
    dst_prod = pop_job.dst_row * cfg.scanline_pitch;
    keyed    = (cfg.color_key != 32'd0) && (pop_job.pix == cfg.color_key);
  end

  always_comb begin
    status_nxt   = ccb_pkg::STATUS_NO_BLIT;
    clip_w_nxt   = '0;
    clip_h_nxt   = '0;
    src_addr_nxt = '0;
    dst_addr_nxt = '0;
    pix_nxt      = '0;
    we_nxt       = 1'b0;
    last_nxt     = 1'b0;
    unique case (pop_job.kind)
      ccb_pkg::JOB_START_OK: begin
        status_nxt = ccb_pkg::STATUS_OK;
        clip_w_nxt = pop_job.clip_w;
        clip_h_nxt = pop_job.clip_h;
      end
      ccb_pkg::JOB_START_EMPTY: begin
        status_nxt = ccb_pkg::STATUS_EMPTY;
      end
      ccb_pkg::JOB_PIXEL: begin
        status_nxt   = ccb_pkg::STATUS_OK;
        src_addr_nxt = src_prod[23:0] + {11'd0, pop_job.src_col};
        dst_addr_nxt = dst_prod[23:0] + {11'd0, pop_job.dst_col};
        pix_nxt      = pop_job.pix;
        we_nxt       = !keyed;
        last_nxt     = pop_job.last;
      end
      ccb_pkg::JOB_NO_BLIT: begin
        status_nxt = ccb_pkg::STATUS_NO_BLIT;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load)              out_valid_nxt = 1'b1;
    else if (out_ch.ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= out_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status_r   <= status_nxt;
      clip_w_r   <= clip_w_nxt;
      clip_h_r   <= clip_h_nxt;
      src_addr_r <= src_addr_nxt;
      dst_addr_r <= dst_addr_nxt;
      pix_r      <= pix_nxt;
      we_r       <= we_nxt;
      last_r     <= last_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = status_r;
  assign out_ch.clip_width   = clip_w_r;
  assign out_ch.clip_height  = clip_h_r;
  assign out_ch.source_addr  = src_addr_r;
  assign out_ch.dest_addr    = dst_addr_r;
  assign out_ch.pixel_out    = pix_r;
  assign out_ch.write_enable = we_r;
  assign out_ch.last         = last_r;

endmodule

>>> sv/clipped_color_key_blit_unit.sv
// Top level of the clipped color-key blit unit: config registers, front, queue, back.
// Path: an accepted beat enters the job queue, then the output register that drives out_ch.
// Throughput: one beat per cycle while the queue is not full, start and pixel alike; the
//   raster counters step per accepted pixel; the back end forms both addresses per cycle.
// Stalls: a two-entry job queue plus the output register absorb out_ch backpressure.
// Reset: synchronous, active low; clears config registers, blit state and queue.
module clipped_color_key_blit_unit (
  input  logic      clk,
  input  logic      rst_n,
  ccb_in_if.sink    in_ch,
  ccb_out_if.source out_ch,
  ccb_cfg_if.sink   cfg_ch
);

  ccb_pkg::cfg_regs_t cfg_r, cfg_nxt;
  ccb_pkg::job_t      push_job, pop_job;
  logic               push_valid, q_full, pop_valid, pop_ready;

  // Config writes are always taken; an index past the register list is dropped.
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        ccb_pkg::REG_SRC_WIDTH:  cfg_nxt.source_image_width  = cfg_ch.data[12:0];
        ccb_pkg::REG_SRC_HEIGHT: cfg_nxt.source_image_height = cfg_ch.data[12:0];
        ccb_pkg::REG_SCR_WIDTH:  cfg_nxt.screen_width        = cfg_ch.data[12:0];
        ccb_pkg::REG_SCR_HEIGHT: cfg_nxt.screen_height       = cfg_ch.data[12:0];
        ccb_pkg::REG_PITCH:      cfg_nxt.scanline_pitch      = cfg_ch.data[12:0];
        ccb_pkg::REG_COLOR_KEY:  cfg_nxt.color_key           = cfg_ch.data;
        default:                 cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cfg_r <= '0;
    else        cfg_r <= cfg_nxt;
  end

  // Front end: classify each beat, clip starts, step raster counters.
  ccb_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .cfg        (cfg_r),
    .q_full     (q_full),
    .push_valid (push_valid),
    .push_job   (push_job)
  );

  // Decouple the two ends so each can stall on its own.
  ccb_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_job   (push_job),
    .full       (q_full),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job)
  );

  // Back end: addresses, color key, output register.
  ccb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_job   (pop_job),
    .out_ch    (out_ch)
  );

endmodule

>>> sv/ccb_checker.sv
// Port-level checks of the blit unit and the bind that attaches them.
module ccb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [12:0] out_clip_width,
  input logic [23:0] out_source_addr,
  input logic [23:0] out_dest_addr,
  input logic        out_write_enable,
  input logic        out_last
);

  // Hold a stalled result beat.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // Nothing is shown in the cycle after reset.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // Failed beats carry no write, no last flag and no addresses.
  a_fail_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ccb_pkg::STATUS_OK) |->
      !out_write_enable && !out_last && (out_source_addr == 24'd0) &&
      (out_dest_addr == 24'd0))
    else $error("failed beat carries pixel data");

  // A last flag only ends a pixel beat, never a start response.
  a_last_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> (out_status == ccb_pkg::STATUS_OK) &&
      (out_clip_width == 13'd0))
    else $error("last flag on a non-pixel beat");

endmodule

bind clipped_color_key_blit_unit ccb_checker u_ccb_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_status       (out_ch.status),
  .out_clip_width   (out_ch.clip_width),
  .out_source_addr  (out_ch.source_addr),
  .out_dest_addr    (out_ch.dest_addr),
  .out_write_enable (out_ch.write_enable),
  .out_last         (out_ch.last)
);
